FILE: rtl/gtte_pkg.sv
// Shared types and constants for the gated track table extrapolator.
`timescale 1ns / 1ps
`default_nettype none
package gtte_pkg;

	localparam int unsigned GateW = 23;
	localparam logic [GateW-1:0] GateReset = 23'd480;
	localparam int unsigned MaxResults = 16;

	typedef enum logic [1:0] {
		ST_REPLACED = 2'd0,
		ST_APPENDED = 2'd1,
		ST_DROPPED  = 2'd2
	} add_status_t;

	typedef struct packed {
		logic               req_type;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [31:0]        stamp_time;
		logic [15:0]        track_weight;
		logic [31:0]        expire_time;
		logic [31:0]        now_time;
	} in_word_t;

	typedef struct packed {
		logic signed [23:0] seed_x;
		logic signed [23:0] seed_y;
		logic signed [23:0] origin_x;
		logic signed [23:0] origin_y;
		logic [15:0]        seed_weight;
		logic               has_seed;
		logic [1:0]         add_status;
		logic [3:0]         slot_index;
		logic               last_result;
	} out_word_t;

	// One stored track
	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [31:0]        stamp;
		logic [15:0]        wt;
		logic [31:0]        expiry;
	} track_t;

	// Control a cell receives each cycle
	typedef struct packed {
		logic write;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/gtte_cell.sv
// One table slot: holds a track, compares it against the request, shifts in a read chain.
`timescale 1ns / 1ps
`default_nettype none
module gtte_cell (
	input  wire logic                          clk,
	input  wire gtte_pkg::cell_ctl_t           ctl,
	input  wire gtte_pkg::track_t              wr_data,
	input  wire logic [gtte_pkg::GateW-1:0]    gate,
	input  wire gtte_pkg::track_t              chain_in,
	output gtte_pkg::track_t                   chain_out,
	output logic                               match
);
	gtte_pkg::track_t track_q;
	gtte_pkg::track_t shift_q;
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	logic [24:0] ax;
	logic [24:0] ay;

	// Store new track; load, advance or hold the read chain
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			track_q <= wr_data;
		end
		if (ctl.load) begin
			shift_q <= track_q;
		end else if (ctl.shift) begin
			shift_q <= chain_in;
		end
	end

	// Gate test against this slot
	always_comb begin
		dx = 25'(wr_data.pos_x) - 25'(track_q.pos_x);
		dy = 25'(wr_data.pos_y) - 25'(track_q.pos_y);
		ax = dx[24] ? 25'(-dx) : 25'(dx);
		ay = dy[24] ? 25'(-dy) : 25'(dy);
		match = (ax < {2'b00, gate}) && (ay < {2'b00, gate});
	end

	assign chain_out = shift_q;
endmodule
`default_nettype wire

FILE: rtl/gtte_extrap.sv
// Two-stage extrapolation of one axis with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module gtte_extrap (
	input  wire logic               clk,
	input  wire logic signed [23:0] pos,
	input  wire logic signed [15:0] vel,
	input  wire logic signed [32:0] elapsed,
	output logic signed [23:0]      res
);
	logic signed [48:0] prod_s1;
	logic signed [23:0] pos_s1;
	logic signed [35:0] disp;
	logic signed [36:0] sum;

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= 49'(vel) * 49'(elapsed);
		pos_s1  <= pos;
	end

	// Round half up, add, saturate
	always_comb begin
		disp = 36'((prod_s1 + 49'sd8192) >>> 14);
		sum  = 37'(disp) + 37'(pos_s1);
		if (sum > 37'sd8388607) begin
			res = 24'sh7FFFFF;
		end else if (sum < -37'sd8388608) begin
			res = 24'sh800000;
		end else begin
			res = sum[23:0];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/gated_track_table_extrapolator.sv
// Gated track table extrapolator: a row of slot cells with a shift chain feeding a seed pipe.
// An add is compared against every slot cell at once in the cycle after it is accepted; the
// first matching slot (or the next free one) is written and one result word is given, so the
// next request can be taken once that word is in the output register. A query loads every
// slot into the cells' shift chain and reads one slot per cycle out of its end while the
// output register is free; a live track holds the walk while it goes through the two-stage
// multiply and saturate pipe. Each seed waits in a holding register until the next one
// arrives, so the final word can carry last_result. A query gives at most 16 seeds and
// waits whenever an output word waits for out_ready. The output register lets the next
// request be taken while the last word waits. Config writes set the gate half-width (reset
// 480 = 30 m) and belong between requests. The table needs no clearing after reset: only
// slots below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module gated_track_table_extrapolator #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire gtte_pkg::in_word_t         in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output gtte_pkg::out_word_t             out_data,
	input  wire logic                       cfg_we,
	input  wire logic [gtte_pkg::GateW-1:0] cfg_data
);
	localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_ADD, S_LOAD, S_WALK, S_DRAIN, S_EMIT} state_t;

	state_t state_q;
	gtte_pkg::in_word_t req_q;
	logic [gtte_pkg::GateW-1:0] gate_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] walk_q;
	logic [4:0] seeds_q;
	logic [TABLE_DEPTH-1:0] wr_sel;
	logic load;
	logic step;
	logic [TABLE_DEPTH-1:0] match;
	gtte_pkg::track_t chain [TABLE_DEPTH+1];
	gtte_pkg::track_t wr_track;
	logic [IdxW-1:0] hit_idx;
	logic hit;
	logic out_free;
	gtte_pkg::out_word_t add_word;
	gtte_pkg::out_word_t seed_word;
	gtte_pkg::out_word_t last_word;
	gtte_pkg::out_word_t held_q;
	logic held_v_q;
	// Seed pipe
	logic v_s1, v_s2;
	logic [3:0] slot_s1, slot_s2;
	gtte_pkg::track_t trk_s1;
	gtte_pkg::track_t trk_s2;
	logic signed [23:0] sx, sy;
	logic signed [32:0] elapsed;
	logic signed [32:0] elapsed_s1;
	logic live;
	logic pipe_busy;

	assign wr_track = '{pos_x: req_q.pos_x, pos_y: req_q.pos_y, vel_x: req_q.vel_x,
		vel_y: req_q.vel_y, stamp: req_q.stamp_time, wt: req_q.track_weight,
		expiry: req_q.expire_time};
	assign chain[TABLE_DEPTH] = wr_track;

	// Row of slot cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		gtte_pkg::cell_ctl_t cell_ctl;
		assign cell_ctl = '{write: wr_sel[i], load: load, shift: step};
		gtte_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.wr_data   (wr_track),
			.gate      (gate_q),
			.chain_in  (chain[i+1]),
			.chain_out (chain[i]),
			.match     (match[i])
		);
	end

	// Pick first valid matching slot
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (match[i] && (CntW'(i) < count_q)) begin
				hit = 1'b1;
				hit_idx = IdxW'(i);
			end
		end
	end

	// Write the slot only in the cycle the add result goes out
	always_comb begin
		wr_sel = '0;
		if (state_q == S_ADD && out_free) begin
			if (hit) begin
				wr_sel[hit_idx] = 1'b1;
			end else if (count_q < CntW'(TABLE_DEPTH)) begin
				wr_sel[IdxW'(count_q)] = 1'b1;
			end
		end
	end

	assign load = (state_q == S_LOAD);
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign pipe_busy = v_s1 || v_s2;
	// Advance the walk only when the pipe cannot collide with a held word
	assign step = (state_q == S_WALK) && !pipe_busy && out_free;

	// Walk entry: fill, expiry and seed-limit test and elapsed time
	assign live = (walk_q < count_q) && (chain[0].expiry >= req_q.now_time)
		&& (seeds_q < 5'(gtte_pkg::MaxResults));
	assign elapsed = 33'({1'b0, req_q.now_time}) - 33'({1'b0, chain[0].stamp});

	gtte_extrap u_ex (.clk(clk), .pos(trk_s1.pos_x), .vel(trk_s1.vel_x),
		.elapsed(elapsed_s1), .res(sx));
	gtte_extrap u_ey (.clk(clk), .pos(trk_s1.pos_y), .vel(trk_s1.vel_y),
		.elapsed(elapsed_s1), .res(sy));

	// Result words for an add, a seed and the end of a query
	always_comb begin
		add_word = '0;
		add_word.last_result = 1'b1;
		if (hit) begin
			add_word.add_status = gtte_pkg::ST_REPLACED;
			add_word.slot_index = 4'(hit_idx);
		end else if (count_q < CntW'(TABLE_DEPTH)) begin
			add_word.add_status = gtte_pkg::ST_APPENDED;
			add_word.slot_index = 4'(count_q);
		end else begin
			add_word.add_status = gtte_pkg::ST_DROPPED;
		end
		last_word = '0;
		if (held_v_q) begin
			last_word = held_q;
		end
		last_word.last_result = 1'b1;
	end

	assign seed_word = '{seed_x: sx, seed_y: sy, origin_x: trk_s2.pos_x,
		origin_y: trk_s2.pos_y, seed_weight: trk_s2.wt, has_seed: 1'b1,
		add_status: gtte_pkg::ST_REPLACED, slot_index: slot_s2, last_result: 1'b0};

	// Request capture, seed pipe and holding register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (step) begin
			trk_s1 <= chain[0];
			elapsed_s1 <= elapsed;
			slot_s1 <= 4'(walk_q);
		end
		trk_s2 <= trk_s1;
		slot_s2 <= slot_s1;
		if (v_s2) begin
			held_q <= seed_word;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gate_q <= gtte_pkg::GateReset;
			count_q <= '0;
			walk_q <= '0;
			seeds_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			held_v_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				gate_q <= cfg_data;
			end
			v_s1 <= step && live;
			v_s2 <= v_s1;

			// Hand out a word or drop the accepted one
			if (state_q == S_ADD && out_free) begin
				out_valid <= 1'b1;
				out_data <= add_word;
			end else if (state_q == S_EMIT) begin
				out_valid <= 1'b1;
				out_data <= last_word;
			end else if (v_s2 && held_v_q) begin
				out_valid <= 1'b1;
				out_data <= held_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			if (v_s2) begin
				held_v_q <= 1'b1;
			end else if (state_q == S_EMIT) begin
				held_v_q <= 1'b0;
			end

			if (state_q == S_ADD && out_free && !hit && (count_q < CntW'(TABLE_DEPTH))) begin
				count_q <= count_q + 1'b1;
			end

			if (state_q == S_LOAD) begin
				walk_q <= '0;
				seeds_q <= '0;
			end else if (step) begin
				walk_q <= walk_q + 1'b1;
				if (live) begin
					seeds_q <= seeds_q + 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= in_data.req_type ? S_LOAD : S_ADD;
					end
				end
				S_ADD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (step && walk_q == CntW'(TABLE_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy && out_free) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sim/gated_track_table_extrapolator_tb.sv
// Testbench for the gated track table extrapolator: random and directed adds and queries.
`timescale 1ns / 1ps

// Track table model and the queue of expected result words
class track_scoreboard;
	logic signed [23:0] px [16];
	logic signed [23:0] py [16];
	logic signed [15:0] vx [16];
	logic signed [15:0] vy [16];
	logic [31:0] stamp [16];
	logic [15:0] wt [16];
	logic [31:0] expiry [16];
	int unsigned count;
	logic [22:0] gate;
	gtte_pkg::out_word_t pending [$];
	int errors;

	function new();
		count = 0;
		gate = gtte_pkg::GateReset;
		errors = 0;
	endfunction

	// Move a position by velocity times elapsed ticks, round and saturate
	function logic signed [23:0] project(logic signed [23:0] p, logic signed [15:0] v,
		longint el);
		longint prod, q, r;
		prod = longint'(v) * el + 8192;
		q = prod / 16384;
		if (prod < 0 && q * 16384 != prod) q = q - 1;
		r = longint'(p) + q;
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[23:0];
	endfunction

	// Note an accepted request and queue its result words
	function void note_request(gtte_pkg::in_word_t w);
		gtte_pkg::out_word_t o;
		longint dx, dy, el;
		int slot, n;
		bit hit;
		if (w.req_type == 1'b0) begin
			o = '0;
			o.add_status = gtte_pkg::ST_DROPPED;
			hit = 0;
			slot = 0;
			for (int i = 0; i < count; i++) begin
				dx = longint'(w.pos_x) - longint'(px[i]);
				dy = longint'(w.pos_y) - longint'(py[i]);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				if (dx < gate && dy < gate) begin
					slot = i;
					o.add_status = gtte_pkg::ST_REPLACED;
					hit = 1;
					break;
				end
			end
			if (!hit && count < 16) begin
				slot = count;
				count++;
				o.add_status = gtte_pkg::ST_APPENDED;
				hit = 1;
			end
			if (hit) begin
				px[slot] = w.pos_x; py[slot] = w.pos_y;
				vx[slot] = w.vel_x; vy[slot] = w.vel_y;
				stamp[slot] = w.stamp_time; wt[slot] = w.track_weight;
				expiry[slot] = w.expire_time;
			end
			o.slot_index = slot[3:0];
			o.last_result = 1'b1;
			pending.insert(pending.size(), o);
			return;
		end
		n = 0;
		for (int i = 0; i < count && n < gtte_pkg::MaxResults; i++) begin
			if (expiry[i] < w.now_time) continue;
			el = longint'(w.now_time) - longint'(stamp[i]);
			o = '0;
			o.seed_x = project(px[i], vx[i], el);
			o.seed_y = project(py[i], vy[i], el);
			o.origin_x = px[i];
			o.origin_y = py[i];
			o.seed_weight = wt[i];
			o.has_seed = 1'b1;
			o.slot_index = i[3:0];
			pending.insert(pending.size(), o);
			n++;
		end
		if (n == 0) begin
			o = '0;
			o.last_result = 1'b1;
			pending.insert(pending.size(), o);
		end else begin
			o = pending.pop_back();
			o.last_result = 1'b1;
			pending.insert(pending.size(), o);
		end
	endfunction

	// Compare one result word with the oldest expectation
	function void check_result(gtte_pkg::out_word_t a);
		gtte_pkg::out_word_t e;
		if (pending.size() == 0) begin
			$error("unexpected result word %h", a);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.seed_x !== e.seed_x) begin
			$error("seed_x exp %0d got %0d", e.seed_x, a.seed_x); errors++; end
		if (a.seed_y !== e.seed_y) begin
			$error("seed_y exp %0d got %0d", e.seed_y, a.seed_y); errors++; end
		if (a.origin_x !== e.origin_x) begin
			$error("origin_x exp %0d got %0d", e.origin_x, a.origin_x); errors++; end
		if (a.origin_y !== e.origin_y) begin
			$error("origin_y exp %0d got %0d", e.origin_y, a.origin_y); errors++; end
		if (a.seed_weight !== e.seed_weight) begin
			$error("seed_weight exp %0d got %0d", e.seed_weight, a.seed_weight); errors++; end
		if (a.has_seed !== e.has_seed) begin
			$error("has_seed exp %0d got %0d", e.has_seed, a.has_seed); errors++; end
		if (a.add_status !== e.add_status) begin
			$error("add_status exp %0d got %0d", e.add_status, a.add_status); errors++; end
		if (a.slot_index !== e.slot_index) begin
			$error("slot_index exp %0d got %0d", e.slot_index, a.slot_index); errors++; end
		if (a.last_result !== e.last_result) begin
			$error("last_result exp %0d got %0d", e.last_result, a.last_result); errors++; end
	endfunction
endclass

module gated_track_table_extrapolator_tb;
	localparam int Watchdog = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	gtte_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	gtte_pkg::out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [gtte_pkg::GateW-1:0] cfg_data = '0;

	track_scoreboard board;
	bit quiet_tail = 0;
	bit hold_sink = 0;
	int idle_cycles = 0;

	gated_track_table_extrapolator #(.TABLE_DEPTH(16)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check result words and track stalls of the whole block
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= Watchdog) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Sink side: random stall bursts, a forced long hold, none in the tail
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) out_ready <= 1'b0;
			else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9);
				out_ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else out_ready <= 1'b1;
		end
	end

	// Offer one word and hold it until taken; valid stays up unless an idle burst follows
	task automatic send_word(gtte_pkg::in_word_t w);
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_request(w);
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_gate(logic [gtte_pkg::GateW-1:0] g);
		cfg_data <= g;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.gate = g;
	endtask

	function automatic gtte_pkg::in_word_t make_add(logic signed [23:0] x,
		logic signed [23:0] y);
		gtte_pkg::in_word_t w;
		w.req_type = 1'b0;
		w.pos_x = x; w.pos_y = y;
		w.vel_x = 16'($urandom); w.vel_y = 16'($urandom);
		w.stamp_time = $urandom; w.track_weight = 16'($urandom);
		w.expire_time = $urandom; w.now_time = $urandom;
		return w;
	endfunction

	function automatic gtte_pkg::in_word_t make_query(logic [31:0] t);
		gtte_pkg::in_word_t w;
		w = make_add(24'($urandom), 24'($urandom));
		w.req_type = 1'b1;
		w.now_time = t;
		return w;
	endfunction

	// Random word, mostly near a cluster of positions so replacements happen
	function automatic gtte_pkg::in_word_t random_word();
		gtte_pkg::in_word_t w;
		logic signed [23:0] cx, cy;
		cx = $signed(24'($urandom_range(0, 7) * 2000)) - 24'sd6000;
		cy = $signed(24'($urandom_range(0, 3) * 2000));
		if ($urandom_range(0, 3) == 0) w = make_add(24'($urandom), 24'($urandom));
		else w = make_add(cx + $signed(24'($urandom_range(0, 900))) - 24'sd450,
			cy + $signed(24'($urandom_range(0, 900))) - 24'sd450);
		if ($urandom_range(0, 2) == 0) begin
			w.req_type = 1'b1;
			w.now_time = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 20);
		end else begin
			w.stamp_time = $urandom_range(0, 1 << 20);
			w.expire_time = ($urandom_range(0, 3) == 0) ? $urandom : 32'hFFFF_FFFF;
		end
		return w;
	endfunction

	initial begin
		gtte_pkg::in_word_t w;
		board = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty query, extremes, exact gate edge, expiry edge
		send_word(make_query(32'd0));
		w = make_add(24'sh7FFFFF, 24'sh800000);
		w.vel_x = 16'sh7FFF; w.vel_y = 16'sh8000;
		w.stamp_time = 32'd0; w.expire_time = 32'hFFFF_FFFF; w.track_weight = 16'hFFFF;
		send_word(w);
		w = make_add(24'sh800000, 24'sh7FFFFF);
		w.vel_x = 16'sh8000; w.vel_y = 16'sh7FFF;
		w.stamp_time = 32'hFFFF_FFFF; w.expire_time = 32'd100; w.track_weight = 16'h0;
		send_word(w);
		send_word(make_add(24'sd0, 24'sd0));
		send_word(make_add(24'sd480, 24'sd0));
		send_word(make_add(24'sd479, 24'sd479));
		send_word(make_query(32'd100));
		send_word(make_query(32'd101));
		send_word(make_query(32'hFFFF_FFFF));
		send_word(make_query(32'h8000_0000));
		drain_results();

		// Zero gate: fill the table until drops
		write_gate('0);
		for (int i = 0; i < 16; i++) send_word(make_add(24'sd5, 24'sd5));
		send_word(make_query(32'd0));
		drain_results();

		// Widest gate with random adds, then a random gate
		write_gate({gtte_pkg::GateW{1'b1}});
		for (int i = 0; i < 4; i++) send_word(make_add(24'($urandom), 24'($urandom)));
		drain_results();
		write_gate(gtte_pkg::GateW'($urandom_range(1, 4000)));
		drain_results();

		// Random part with a long hold on the sink
		for (int n = 0; n < 280; n++) begin
			if (n == 60) fork
				begin
					@(negedge clk);
					hold_sink = 1;
					repeat (200) @(negedge clk);
					hold_sink = 0;
				end
			join_none
			if (n == 150) drain_results();
			if (n == 200) begin
				drain_results();
				write_gate(gtte_pkg::GateReset);
			end
			if (n == 250) quiet_tail = 1;
			send_word(random_word());
		end

		drain_results();
		if (board.errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule

FILE: sim.f
rtl/gtte_pkg.sv
rtl/gtte_cell.sv
rtl/gtte_extrap.sv
rtl/gated_track_table_extrapolator.sv
sim/gated_track_table_extrapolator_tb.sv
